[rtl/hangul_glyph_offset_composer_assert.svh]
// Assertion macros used by the glyph offset composer checker.
`ifndef HANGUL_GLYPH_OFFSET_COMPOSER_ASSERT_SVH
`define HANGUL_GLYPH_OFFSET_COMPOSER_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define HGOC_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define HGOC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/hgoc_pkg.sv]
// Package: field widths, font layout constants and jamo tables for the composer.
`default_nettype none

package hgoc_pkg;

  localparam int unsigned CodeW  = 16;
  localparam int unsigned OffsW  = 14;
  localparam int unsigned JamoW  = 5;

  // Font memory layout in bytes
  localparam int unsigned PieceBytes    = 32;
  localparam int unsigned InitSetSize   = 640;
  localparam int unsigned MedBase       = 5120;
  localparam int unsigned MedRegionSize = 2816;
  localparam int unsigned MedSetSize    = 704;
  localparam int unsigned FinBase       = MedBase + MedRegionSize;
  localparam int unsigned FinSetSize    = 896;

  // Initial indexes that take the first medial set pair
  localparam logic [JamoW-1:0] IdxGiyeok = JamoW'(1);
  localparam logic [JamoW-1:0] IdxKieuk  = JamoW'(16);

  // Largest legal raw field codes
  localparam logic [JamoW-1:0] InitFieldMax = JamoW'(20);
  localparam logic [JamoW-1:0] MedFieldMax  = JamoW'(29);
  localparam logic [JamoW-1:0] FinFieldMax  = JamoW'(29);

  typedef logic [CodeW-1:0] code_t;
  typedef logic [OffsW-1:0] offset_t;

  typedef struct packed {
    offset_t initial_offset;
    offset_t medial_offset;
    offset_t final_offset;
    logic    has_final;
    logic    code_error;
  } glyph_t;

  // Raw jamo field to index; entries past the legal range are unused
  localparam logic [JamoW-1:0] InitMap [32] = '{
    5'd0, 5'd0, 5'd1, 5'd2, 5'd3, 5'd4, 5'd5, 5'd6, 5'd7, 5'd8, 5'd9, 5'd10,
    5'd11, 5'd12, 5'd13, 5'd14, 5'd15, 5'd16, 5'd17, 5'd18, 5'd19,
    5'd0, 5'd0, 5'd0, 5'd0, 5'd0, 5'd0, 5'd0, 5'd0, 5'd0, 5'd0, 5'd0
  };

  localparam logic [JamoW-1:0] MedMap [32] = '{
    5'd0, 5'd0, 5'd0, 5'd1, 5'd2, 5'd3, 5'd4, 5'd5, 5'd0, 5'd0, 5'd6, 5'd7,
    5'd8, 5'd9, 5'd10, 5'd11, 5'd0, 5'd0, 5'd12, 5'd13, 5'd14, 5'd15,
    5'd16, 5'd17, 5'd0, 5'd0, 5'd18, 5'd19, 5'd20, 5'd21, 5'd0, 5'd0
  };

  localparam logic [JamoW-1:0] FinMap [32] = '{
    5'd0, 5'd0, 5'd1, 5'd2, 5'd3, 5'd4, 5'd5, 5'd6, 5'd7, 5'd8, 5'd9, 5'd10,
    5'd11, 5'd12, 5'd13, 5'd14, 5'd15, 5'd16, 5'd0, 5'd17, 5'd18, 5'd19,
    5'd20, 5'd21, 5'd22, 5'd23, 5'd24, 5'd25, 5'd26, 5'd27, 5'd0, 5'd0
  };

  // Bul set tables indexed by medial index
  localparam logic [2:0] InitSetOpen [32] = '{
    3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd1, 3'd3, 3'd3,
    3'd3, 3'd1, 3'd2, 3'd4, 3'd4, 3'd4, 3'd2, 3'd1, 3'd3, 3'd0,
    3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0
  };

  localparam logic [2:0] InitSetClosed [32] = '{
    3'd0, 3'd5, 3'd5, 3'd5, 3'd5, 3'd5, 3'd5, 3'd5, 3'd5, 3'd6, 3'd7, 3'd7,
    3'd7, 3'd6, 3'd6, 3'd7, 3'd7, 3'd7, 3'd6, 3'd6, 3'd7, 3'd5,
    3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0
  };

  localparam logic [1:0] FinSet [32] = '{
    2'd0, 2'd0, 2'd2, 2'd0, 2'd2, 2'd1, 2'd2, 2'd1, 2'd2, 2'd3, 2'd0, 2'd2,
    2'd1, 2'd3, 2'd3, 2'd1, 2'd2, 2'd1, 2'd3, 2'd3, 2'd1, 2'd1,
    2'd0, 2'd0, 2'd0, 2'd0, 2'd0, 2'd0, 2'd0, 2'd0, 2'd0, 2'd0
  };

endpackage

`default_nettype wire

[rtl/hgoc_if.sv]
// Interfaces: code request channel and glyph offset result channel.
`default_nettype none

interface hgoc_code_if
  import hgoc_pkg::*;
();
  logic  valid;
  logic  ready;
  code_t johab_code;

  modport source (output valid, output johab_code, input ready);
  modport sink   (input valid, input johab_code, output ready);
endinterface

interface hgoc_glyph_if
  import hgoc_pkg::*;
();
  logic    valid;
  logic    ready;
  offset_t initial_offset;
  offset_t medial_offset;
  offset_t final_offset;
  logic    has_final;
  logic    code_error;

  modport source (output valid, output initial_offset, output medial_offset,
                  output final_offset, output has_final, output code_error,
                  input ready);
  modport sink   (input valid, input initial_offset, input medial_offset,
                  input final_offset, input has_final, input code_error,
                  output ready);
endinterface

`default_nettype wire

[rtl/hangul_glyph_offset_composer.sv]
// Codes pass the input register; results are offered from the result register.
// Throughput: one code request per cycle unless the output is stalled; the input
// register feeds the lookup and offset logic, which lands in the result register.
// Each register stage advances when the stage after it is empty or being drained.
// Reset (asynchronous, active low) empties both stages; data is not reset.
`default_nettype none

module hangul_glyph_offset_composer
  import hgoc_pkg::*;
(
  input  wire          clk_i,
  input  wire          rst_ni,
  hgoc_code_if.sink    code_i,
  hgoc_glyph_if.source glyph_o
);

  logic   in_vld_q, in_vld_d;
  code_t  code_q;
  logic   out_vld_q, out_vld_d;
  glyph_t result_q;
  glyph_t result_d;
  logic   out_free;
  logic   in_take;

  // Stage handshakes
  assign out_free     = ~out_vld_q | glyph_o.ready;
  assign code_i.ready = ~in_vld_q | out_free;
  assign in_take      = code_i.valid & code_i.ready;

  // Advance valid flags
  assign in_vld_d  = in_take | (in_vld_q & ~out_free);
  assign out_vld_d = out_free ? in_vld_q : out_vld_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      in_vld_q  <= in_vld_d;
      out_vld_q <= out_vld_d;
    end
  end

  // Capture the code request
  always_ff @(posedge clk_i) begin
    if (in_take) begin
      code_q <= code_i.johab_code;
    end
  end

  hgoc_compose u_compose (
    .johab_code_i (code_q),
    .glyph_o      (result_d)
  );

  // Hold the result until taken
  always_ff @(posedge clk_i) begin
    if (out_free && in_vld_q) begin
      result_q <= result_d;
    end
  end

  assign glyph_o.valid          = out_vld_q;
  assign glyph_o.initial_offset = result_q.initial_offset;
  assign glyph_o.medial_offset  = result_q.medial_offset;
  assign glyph_o.final_offset   = result_q.final_offset;
  assign glyph_o.has_final      = result_q.has_final;
  assign glyph_o.code_error     = result_q.code_error;

endmodule

`default_nettype wire

[rtl/hgoc_compose.sv]
// Jamo decode, 8x4x4 bul set choice and glyph piece offset arithmetic.
`default_nettype none

module hgoc_compose
  import hgoc_pkg::*;
(
  input  code_t  johab_code_i,
  output glyph_t glyph_o
);

  logic [JamoW-1:0] fi, fm, ff;
  logic [JamoW-1:0] ini, med, fin;
  logic             err;
  logic             closed;
  logic             first_pair;
  logic [1:0]       med_set;
  logic [2:0]       init_set;
  logic [1:0]       fin_set;
  offset_t          o_i, o_m, o_f;

  // Split the code into jamo fields and flag out-of-table codes
  assign fi  = johab_code_i[14:10];
  assign fm  = johab_code_i[9:5];
  assign ff  = johab_code_i[4:0];
  assign err = (fi > InitFieldMax) || (fm > MedFieldMax) || (ff > FinFieldMax);

  // Map fields to jamo indexes
  assign ini    = InitMap[fi];
  assign med    = MedMap[fm];
  assign fin    = FinMap[ff];
  assign closed = (fin != '0);

  // Pick bul sets
  assign first_pair = (ini == IdxGiyeok) || (ini == IdxKieuk);
  assign med_set    = {closed, ~first_pair};
  assign init_set   = closed ? InitSetClosed[med] : InitSetOpen[med];
  assign fin_set    = FinSet[med];

  // Offsets into the composed font memory
  assign o_i = OffsW'(int'(init_set) * InitSetSize + int'(ini) * PieceBytes);
  assign o_m = OffsW'(MedBase + int'(med_set) * MedSetSize + int'(med) * PieceBytes);
  assign o_f = closed
             ? OffsW'(FinBase + int'(fin_set) * FinSetSize + int'(fin) * PieceBytes)
             : '0;

  // Zero the offsets and has_final and raise code_error on an error code
  always_comb begin
    if (err) begin
      glyph_o.initial_offset = '0;
      glyph_o.medial_offset  = '0;
      glyph_o.final_offset   = '0;
      glyph_o.has_final      = 1'b0;
      glyph_o.code_error     = 1'b1;
    end else begin
      glyph_o.initial_offset = o_i;
      glyph_o.medial_offset  = o_m;
      glyph_o.final_offset   = o_f;
      glyph_o.has_final      = closed;
      glyph_o.code_error     = 1'b0;
    end
  end

endmodule

`default_nettype wire

[rtl/hgoc_checker.sv]
// Port-level checks for the glyph offset composer, bound to the top level.
`default_nettype none
`include "hangul_glyph_offset_composer_assert.svh"

module hgoc_checker
  import hgoc_pkg::*;
(
  input wire     clk_i,
  input wire     rst_ni,
  input wire     out_valid_i,
  input wire     out_ready_i,
  input offset_t initial_offset_i,
  input offset_t medial_offset_i,
  input offset_t final_offset_i,
  input wire     has_final_i,
  input wire     code_error_i
);

  // A stalled result stays offered and unchanged
  `HGOC_ASSERT_NEXT(a_stall_hold, clk_i, rst_ni, out_valid_i && !out_ready_i, out_valid_i && $stable(initial_offset_i) && $stable(medial_offset_i) && $stable(final_offset_i) && $stable(has_final_i) && $stable(code_error_i), "stalled result changed")

  // An error result carries no offsets
  `HGOC_ASSERT_IMPL(a_err_zero, clk_i, rst_ni, out_valid_i && code_error_i, initial_offset_i == '0 && medial_offset_i == '0 && final_offset_i == '0 && !has_final_i, "error result has offsets")

  // No final piece means a zero final offset
  `HGOC_ASSERT_IMPL(a_open_final, clk_i, rst_ni, out_valid_i && !has_final_i, final_offset_i == '0, "final offset without final piece")

  // Good results land in their own font regions
  `HGOC_ASSERT_IMPL(a_regions, clk_i, rst_ni, out_valid_i && !code_error_i, int'(initial_offset_i) < MedBase && int'(medial_offset_i) >= MedBase && int'(medial_offset_i) < FinBase && (!has_final_i || int'(final_offset_i) >= FinBase), "offset outside its region")

endmodule

bind hangul_glyph_offset_composer hgoc_checker u_hgoc_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .out_valid_i      (glyph_o.valid),
  .out_ready_i      (glyph_o.ready),
  .initial_offset_i (glyph_o.initial_offset),
  .medial_offset_i  (glyph_o.medial_offset),
  .final_offset_i   (glyph_o.final_offset),
  .has_final_i      (glyph_o.has_final),
  .code_error_i     (glyph_o.code_error)
);

`default_nettype wire
